/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent checked in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg
// Types, codes and the rank compare of the top-K sorted selector.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MAX_KEEP_DEF = 64;
  localparam int CFG_IW       = 8;
  localparam int CFG_DW       = 8;

  localparam logic [CFG_IW-1:0] CFG_ASCENDING  = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_KEEP_LIMIT = 8'd1;

  localparam logic       ASCENDING_RST  = 1'b1;
  localparam logic [6:0] KEEP_LIMIT_RST = 7'd64;

  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [63:0] sort_key;
    logic        [31:0] doc_id;
    logic               doc_live;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] out_key;
    logic        [31:0] out_doc_id;
    logic               empty_res;
  } out_item_t;

  typedef struct packed {
    logic signed [63:0] key;
    logic        [31:0] id;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF_CMP,
    ST_UP_TEST,
    ST_UP_CMP,
    ST_DN_TEST,
    ST_DN_LR,
    ST_DN_X,
    ST_DR_POP,
    ST_DR_LAST,
    ST_EMIT
  } st_t;

  // a ranks ahead of b: better key, or equal key and smaller id
  function automatic logic ranks_ahead(input entry_t a, input entry_t b, input logic asc);
    logic res;
    if (a.key != b.key) begin
      res = asc ? (a.key < b.key) : (a.key > b.key);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

/* hdl/tks_ram.sv */
// ----------------------------------------------------------------------------
// tks_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* hdl/top_k_sorted_selector_top.sv */
// ----------------------------------------------------------------------------
// top_k_sorted_selector_top
// Keeps the best K documents by sort key in a binary heap, worst at the root.
// ----------------------------------------------------------------------------
// One transaction at a time. A dead offer is dropped; a rejected offer is
// compared with the root and ends there; an empty drain goes straight to its
// result. An insert sifts up a heap level per test and compare; a replace of
// the root, and a drain after its pop and read of the last entry, sift down a
// level per test, child compare and exchange. A result waits while out_stall
// holds the one before it. The steps are set by the single rank comparator
// and the registered read of the heap RAM. The heap RAM has no clearing pass;
// held_r alone marks which entries are live. A write to the ascending or the
// keep-limit register empties the store.
module top_k_sorted_selector_top #(
  parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tks_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tks_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tks_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [tks_pkg::CFG_DW-1:0]    cfg_data
);

  import tks_pkg::*;

  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int LW = CW + 1;

  st_t             state_r, state_nxt;
  logic [CW-1:0]   held_r, held_nxt;
  logic            asc_r, asc_nxt;
  logic [6:0]      keep_limit_r, keep_limit_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            pend_r, pend_nxt;

  entry_t          x_r, x_nxt;
  entry_t          w_r, w_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [IW-1:0]   wi_r, wi_nxt;
  logic            rv_r, rv_nxt;
  out_item_t       res_r, res_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;
  logic [IW-1:0]   raddr_a, raddr_b;
  entry_t          rd_a, rd_b;

  entry_t          cmp_a, cmp_b;
  logic            cmp_ahead;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   cnt_dec;
  logic [IW-1:0]   parent;
  logic [LW-1:0]   l_w, r_w;
  st_t             done_st;

  tks_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_KEEP)
  ) u_heap (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  assign lim = (keep_limit_r == '0) ? CW'(1) :
               ((32'(keep_limit_r) > MAX_KEEP) ? CW'(MAX_KEEP) : CW'(keep_limit_r));
  assign cnt_dec = held_r - CW'(1);
  assign parent  = IW'((i_r - IW'(1)) >> 1);
  assign l_w     = LW'({i_r, 1'b1});
  assign r_w     = l_w + LW'(1);
  assign done_st = pend_r ? ST_EMIT : ST_IDLE;

  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared rank comparator
  always_comb begin
    case (state_r)
      ST_UP_CMP: begin
        cmp_a = rd_a;
        cmp_b = x_r;
      end
      ST_DN_LR: begin
        cmp_a = rd_a;
        cmp_b = rd_b;
      end
      ST_DN_X: begin
        cmp_a = x_r;
        cmp_b = w_r;
      end
      default: begin
        cmp_a = x_r;
        cmp_b = rd_a;
      end
    endcase
    cmp_ahead = ranks_ahead(cmp_a, cmp_b, asc_r);
  end

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    asc_nxt        = asc_r;
    keep_limit_nxt = keep_limit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pend_nxt       = pend_r;
    x_nxt          = x_r;
    w_nxt          = w_r;
    i_nxt          = i_r;
    wi_nxt         = wi_r;
    rv_nxt         = rv_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    we             = 1'b0;
    waddr          = i_r;
    wdata          = x_r;
    raddr_a        = '0;
    raddr_b        = '0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == CFG_ASCENDING) begin
            asc_nxt  = cfg_data[0];
            held_nxt = '0;
          end else if (cfg_index == CFG_KEEP_LIMIT) begin
            keep_limit_nxt = cfg_data[6:0];
            held_nxt       = '0;
          end
        end else if (in_valid) begin
          x_nxt.key = in_data.sort_key;
          x_nxt.id  = in_data.doc_id;
          pend_nxt  = 1'b0;
          if (in_data.command == CMD_OFFER) begin
            if (in_data.doc_live) begin
              if (held_r < lim) begin
                i_nxt     = held_r[IW-1:0];
                held_nxt  = held_r + CW'(1);
                state_nxt = ST_UP_TEST;
              end else begin
                state_nxt = ST_OFF_CMP;
              end
            end
          end else begin
            if (held_r == '0) begin
              res_nxt.out_key    = '0;
              res_nxt.out_doc_id = '0;
              res_nxt.empty_res  = 1'b1;
              pend_nxt           = 1'b1;
              state_nxt          = ST_EMIT;
            end else begin
              state_nxt = ST_DR_POP;
            end
          end
        end
      end
      ST_OFF_CMP: begin
        if (cmp_ahead) begin
          i_nxt     = '0;
          state_nxt = ST_DN_TEST;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UP_TEST: begin
        if (i_r == '0) begin
          we        = 1'b1;
          state_nxt = done_st;
        end else begin
          raddr_a   = parent;
          wi_nxt    = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (cmp_ahead) begin
          wdata     = rd_a;
          i_nxt     = wi_r;
          state_nxt = ST_UP_TEST;
        end else begin
          state_nxt = done_st;
        end
      end
      ST_DN_TEST: begin
        if (l_w >= LW'(held_r)) begin
          we        = 1'b1;
          state_nxt = done_st;
        end else begin
          raddr_a   = l_w[IW-1:0];
          raddr_b   = r_w[IW-1:0];
          wi_nxt    = l_w[IW-1:0];
          rv_nxt    = (r_w < LW'(held_r));
          state_nxt = ST_DN_LR;
        end
      end
      ST_DN_LR: begin
        if (rv_r && cmp_ahead) begin
          w_nxt  = rd_b;
          wi_nxt = wi_r + IW'(1);
        end else begin
          w_nxt = rd_a;
        end
        state_nxt = ST_DN_X;
      end
      ST_DN_X: begin
        we = 1'b1;
        if (cmp_ahead) begin
          wdata     = w_r;
          i_nxt     = wi_r;
          state_nxt = ST_DN_TEST;
        end else begin
          state_nxt = done_st;
        end
      end
      ST_DR_POP: begin
        res_nxt.out_key    = rd_a.key;
        res_nxt.out_doc_id = rd_a.id;
        res_nxt.empty_res  = 1'b0;
        pend_nxt           = 1'b1;
        held_nxt           = cnt_dec;
        if (cnt_dec == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          raddr_a   = cnt_dec[IW-1:0];
          state_nxt = ST_DR_LAST;
        end
      end
      ST_DR_LAST: begin
        x_nxt     = rd_a;
        i_nxt     = '0;
        state_nxt = ST_DN_TEST;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_r       <= '0;
      asc_r        <= ASCENDING_RST;
      keep_limit_r <= KEEP_LIMIT_RST;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      asc_r        <= asc_nxt;
      keep_limit_r <= keep_limit_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    w_r        <= w_nxt;
    i_r        <= i_nxt;
    wi_r       <= wi_nxt;
    rv_r       <= rv_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hdl/tks_checker.sv */
// ----------------------------------------------------------------------------
// tks_checker
// Port-level assertions for the top-K sorted selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tks_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tks_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tks_pkg::out_item_t  out_data
);

  import tks_pkg::*;

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // an accepted drain always leaves the block busy, stalling the input
  `ASSERT_NEXT(a_drain_busy, in_valid && !in_stall && in_data.command == CMD_DRAIN, in_stall)

  // an empty report carries zero key and id
  `ASSERT_NOW(a_empty_zero, out_valid && out_data.empty_res,
              out_data.out_key == '0 && out_data.out_doc_id == '0)

  // a new result is only launched from the busy side
  `ASSERT_NOW(a_rise_busy, $rose(out_valid), $past(in_stall))

endmodule

bind top_k_sorted_selector_top tks_checker u_tks_checker (.*);
